### rtl/core/ffp_pkg.sv
// ============================================================================
// ffp_pkg
// Shared constants and helpers for the three-point Frenet frame pipeline.
// ============================================================================
`default_nettype none

package ffp_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int UNIT_FRAC_BITS_DEF = 14;

    // Significant bits kept after normalizing a vector magnitude.
    localparam int NORM_BITS = 31;

    // Bit length of a magnitude of up to 128 bits.
    function automatic logic [7:0] f_bitlen(input logic [127:0] v);
        logic [7:0] n;
        n = '0;
        for (int k = 0; k < 128; k++) begin
            if (v[k]) n = 8'(k + 1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ffp_if.sv
// ============================================================================
// ffp_stream_if
// Valid/ready channel carrying one payload.
// ============================================================================
`default_nettype none

interface ffp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/ffp_unitize.sv
// ============================================================================
// ffp_unitize
// Pipelined vector normalization: magnitude align, sum of squares, integer
// square root (one stage per two radicand bits), then rounded divide.
// ============================================================================
`default_nettype none

module ffp_unitize
    import ffp_pkg::*;
#(
    parameter int IN_W  = 128,
    parameter int FRAC  = UNIT_FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic signed [IN_W-1:0]     i_vec [3],
    input  wire logic [SIDE_W-1:0]          i_side,
    output logic                            o_valid,
    output logic signed [FRAC+1:0]          o_unit [3],
    output logic                            o_zero,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int SQ_STEPS = 32;
    localparam int QW = NORM_BITS + FRAC + 2;
    localparam int DV_STEPS = FRAC + 2;

    // stage A: magnitude and sign
    logic              r_a_v;
    logic [127:0]      r_a_m [3];
    logic [2:0]        r_a_neg;
    logic [SIDE_W-1:0] r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                logic [127:0] w;
                w = 128'($signed(i_vec[k]));
                r_a_neg[k] <= w[127];
                r_a_m[k]   <= w[127] ? (~w + 128'd1) : w;
            end
            r_a_side <= i_side;
        end
    end

    // stage B: shift to 31 significant bits
    logic              r_b_v;
    logic [30:0]       r_b_s [3];
    logic [2:0]        r_b_neg;
    logic              r_b_zero;
    logic [SIDE_W-1:0] r_b_side;
    logic [7:0]        maxb;

    always_comb begin
        logic [7:0] l0, l1, l2;
        l0 = f_bitlen(r_a_m[0]);
        l1 = f_bitlen(r_a_m[1]);
        l2 = f_bitlen(r_a_m[2]);
        maxb = l0;
        if (l1 > maxb) maxb = l1;
        if (l2 > maxb) maxb = l2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (maxb > 8'(NORM_BITS))
                    r_b_s[k] <= 31'(r_a_m[k] >> (maxb - 8'(NORM_BITS)));
                else
                    r_b_s[k] <= 31'(r_a_m[k] << (8'(NORM_BITS) - maxb));
            end
            r_b_neg  <= r_a_neg;
            r_b_zero <= (maxb == 8'd0);
            r_b_side <= r_a_side;
        end
    end

    // stage C: squares
    logic              r_c_v;
    logic [61:0]       r_c_sq [3];
    logic [30:0]       r_c_s [3];
    logic [2:0]        r_c_neg;
    logic              r_c_zero;
    logic [SIDE_W-1:0] r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c_sq[k] <= 62'(r_b_s[k]) * 62'(r_b_s[k]);
            end
            r_c_s    <= r_b_s;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            r_c_side <= r_b_side;
        end
    end

    // square root pipeline, stage 0 holds the sum
    logic              r_q_v    [SQ_STEPS+1];
    logic [63:0]       r_q_rem  [SQ_STEPS+1];
    logic [63:0]       r_q_root [SQ_STEPS+1];
    logic [30:0]       r_q_s    [SQ_STEPS+1][3];
    logic [2:0]        r_q_neg  [SQ_STEPS+1];
    logic              r_q_zero [SQ_STEPS+1];
    logic [SIDE_W-1:0] r_q_side [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v[0] <= 1'b0;
        end else if (i_en) begin
            r_q_v[0] <= r_c_v;
        end
        if (i_en) begin
            r_q_rem[0]  <= 64'(r_c_sq[0]) + 64'(r_c_sq[1]) + 64'(r_c_sq[2]);
            r_q_root[0] <= '0;
            r_q_s[0]    <= r_c_s;
            r_q_neg[0]  <= r_c_neg;
            r_q_zero[0] <= r_c_zero;
            r_q_side[0] <= r_c_side;
        end
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] n_rem, n_root;
        always_comb begin
            if (r_q_rem[g] >= r_q_root[g] + BIT) begin
                n_rem  = r_q_rem[g] - (r_q_root[g] + BIT);
                n_root = (r_q_root[g] >> 1) + BIT;
            end else begin
                n_rem  = r_q_rem[g];
                n_root = r_q_root[g] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_q_v[g+1] <= r_q_v[g];
            end
            if (i_en) begin
                r_q_rem[g+1]  <= n_rem;
                r_q_root[g+1] <= n_root;
                r_q_s[g+1]    <= r_q_s[g];
                r_q_neg[g+1]  <= r_q_neg[g];
                r_q_zero[g+1] <= r_q_zero[g];
                r_q_side[g+1] <= r_q_side[g];
            end
        end
    end

    // restoring divide: q = (s*2^(FRAC+1) + L) / (2L), one quotient bit per stage
    logic              r_d_v    [DV_STEPS+1];
    logic [QW-1:0]     r_d_rem  [DV_STEPS+1][3];
    logic [FRAC+1:0]   r_d_q    [DV_STEPS+1][3];
    logic [QW-1:0]     r_d_dvs  [DV_STEPS+1];
    logic [2:0]        r_d_neg  [DV_STEPS+1];
    logic              r_d_zero [DV_STEPS+1];
    logic [SIDE_W-1:0] r_d_side [DV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else if (i_en) begin
            r_d_v[0] <= r_q_v[SQ_STEPS];
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d_rem[0][k] <= (QW'(r_q_s[SQ_STEPS][k]) << (FRAC + 1))
                                 + QW'(r_q_root[SQ_STEPS]);
                r_d_q[0][k]   <= '0;
            end
            r_d_dvs[0]  <= QW'(r_q_root[SQ_STEPS]) << 1;
            r_d_neg[0]  <= r_q_neg[SQ_STEPS];
            r_d_zero[0] <= r_q_zero[SQ_STEPS];
            r_d_side[0] <= r_q_side[SQ_STEPS];
        end
    end

    for (genvar g = 0; g < DV_STEPS; g++) begin : g_div
        localparam int SH = DV_STEPS - 1 - g;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_d_v[g+1] <= r_d_v[g];
            end
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    logic [2*QW-1:0] t;
                    t = (2*QW)'(r_d_dvs[g]) << SH;
                    if ((2*QW)'(r_d_rem[g][k]) >= t) begin
                        r_d_rem[g+1][k] <= QW'((2*QW)'(r_d_rem[g][k]) - t);
                        r_d_q[g+1][k]   <= r_d_q[g][k] | ((FRAC+2)'(1) << SH);
                    end else begin
                        r_d_rem[g+1][k] <= r_d_rem[g][k];
                        r_d_q[g+1][k]   <= r_d_q[g][k];
                    end
                end
                r_d_dvs[g+1]  <= r_d_dvs[g];
                r_d_neg[g+1]  <= r_d_neg[g];
                r_d_zero[g+1] <= r_d_zero[g];
                r_d_side[g+1] <= r_d_side[g];
            end
        end
    end

    // output register with sign applied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_d_v[DV_STEPS];
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_d_zero[DV_STEPS])
                    o_unit[k] <= '0;
                else if (r_d_neg[DV_STEPS][k])
                    o_unit[k] <= -$signed(r_d_q[DV_STEPS][k]);
                else
                    o_unit[k] <= $signed(r_d_q[DV_STEPS][k]);
            end
            o_zero <= r_d_zero[DV_STEPS];
            o_side <= r_d_side[DV_STEPS];
        end
    end

endmodule

`default_nettype wire

### rtl/core/frenet_frame_from_three_points_core.sv
// ============================================================================
// frenet_frame_from_three_points_core
// Frenet frame (tangent, normal, binormal) from three path points.
// ============================================================================
// Pipeline: difference and cross-product stages, tangent and binormal
//   normalizers of 54 stages each in parallel, normal product stage,
//   normal normalizer of 54 stages, output register; the square-root
//   and divide stage chains make up most of the depth.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Reset: synchronous active-low i_rst_n clears all valid bits.
`default_nettype none

module frenet_frame_from_three_points_core
    import ffp_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffp_stream_if.sink   i_pts,
    ffp_stream_if.source o_frame
);

    localparam int CW = COORD_WIDTH;
    localparam int UW = UNIT_FRAC_BITS + 2;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    // output skid: stall pipeline only when output register is full and blocked
    logic en;
    logic r_out_v;
    assign en = !r_out_v || o_frame.ready;
    assign i_pts.ready = en;

    // stage 1: differences
    logic                 r_s1_v;
    logic signed [DW-1:0] r_a [3];
    logic signed [DW-1:0] r_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_pts.valid;
        end
        if (en) begin
            r_a[0] <= DW'($signed(i_pts.data.p2_x)) - DW'($signed(i_pts.data.p0_x));
            r_a[1] <= DW'($signed(i_pts.data.p2_y)) - DW'($signed(i_pts.data.p0_y));
            r_a[2] <= DW'($signed(i_pts.data.p2_z)) - DW'($signed(i_pts.data.p0_z));
            r_b[0] <= DW'($signed(i_pts.data.p1_x)) - DW'($signed(i_pts.data.p0_x));
            r_b[1] <= DW'($signed(i_pts.data.p1_y)) - DW'($signed(i_pts.data.p0_y));
            r_b[2] <= DW'($signed(i_pts.data.p1_z)) - DW'($signed(i_pts.data.p0_z));
        end
    end

    // stage 2: cross products a x b, exact
    logic                 r_s2_v;
    logic signed [PW-1:0] r_pp [6];
    logic signed [DW-1:0] r_a2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
        if (en) begin
            r_pp[0] <= PW'(r_a[1]) * PW'(r_b[2]);
            r_pp[1] <= PW'(r_a[2]) * PW'(r_b[1]);
            r_pp[2] <= PW'(r_a[2]) * PW'(r_b[0]);
            r_pp[3] <= PW'(r_a[0]) * PW'(r_b[2]);
            r_pp[4] <= PW'(r_a[0]) * PW'(r_b[1]);
            r_pp[5] <= PW'(r_a[1]) * PW'(r_b[0]);
            r_a2    <= r_a;
        end
    end

    logic signed [127:0] tb_vec  [3];
    logic signed [127:0] tan_vec [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tb_vec[k]  = 128'(r_pp[2*k]) - 128'(r_pp[2*k+1]);
            tan_vec[k] = 128'(r_a2[k]);
        end
    end

    // tangent and binormal normalized in parallel
    logic                  tan_v, b_v, tan_z, b_z;
    logic signed [UW-1:0]  tan_u [3];
    logic signed [UW-1:0]  b_u [3];
    logic [0:0]            tan_side, b_side;

    ffp_unitize #(.IN_W(128), .FRAC(UNIT_FRAC_BITS), .SIDE_W(1)) u_tan (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_s2_v), .i_vec(tan_vec),
        .i_side(1'b0), .o_valid(tan_v), .o_unit(tan_u), .o_zero(tan_z),
        .o_side(tan_side)
    );

    ffp_unitize #(.IN_W(128), .FRAC(UNIT_FRAC_BITS), .SIDE_W(1)) u_bin (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_s2_v), .i_vec(tb_vec),
        .i_side(1'b0), .o_valid(b_v), .o_unit(b_u), .o_zero(b_z), .o_side(b_side)
    );

    // normal = b x t from quantized vectors
    localparam int NP = 2 * UW;
    logic                 r_n_v, r_n_deg;
    logic signed [NP-1:0] r_np [6];
    logic signed [UW-1:0] r_t3 [3];
    logic signed [UW-1:0] r_b3 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (en) begin
            r_n_v <= tan_v;
        end
        if (en) begin
            r_np[0] <= NP'(b_u[1]) * NP'(tan_u[2]);
            r_np[1] <= NP'(b_u[2]) * NP'(tan_u[1]);
            r_np[2] <= NP'(b_u[2]) * NP'(tan_u[0]);
            r_np[3] <= NP'(b_u[0]) * NP'(tan_u[2]);
            r_np[4] <= NP'(b_u[0]) * NP'(tan_u[1]);
            r_np[5] <= NP'(b_u[1]) * NP'(tan_u[0]);
            r_t3    <= tan_u;
            r_b3    <= b_u;
            r_n_deg <= tan_z | b_z | tan_side[0] | b_side[0] | (b_v & 1'b0);
        end
    end

    logic signed [127:0] n_vec [3];
    logic [2*UW-1:0]     n_side_in, n_side_out;
    logic [3*UW*2:0]     n_pack_in, n_pack_out;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_vec[k] = 128'(r_np[2*k]) - 128'(r_np[2*k+1]);
        end
        n_pack_in = {r_n_deg, r_t3[0], r_t3[1], r_t3[2], r_b3[0], r_b3[1], r_b3[2]};
        n_side_in = '0;
    end

    logic                 n_v, n_z;
    logic signed [UW-1:0] n_u [3];

    ffp_unitize #(.IN_W(128), .FRAC(UNIT_FRAC_BITS), .SIDE_W(6*UW+1)) u_nrm (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_n_v), .i_vec(n_vec),
        .i_side(n_pack_in), .o_valid(n_v), .o_unit(n_u), .o_zero(n_z),
        .o_side(n_pack_out)
    );
    assign n_side_out = n_side_in;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= n_v;
        end
        if (en) begin
            o_frame.data.tangent_x  <= n_pack_out[6*UW-1 -: UW];
            o_frame.data.tangent_y  <= n_pack_out[5*UW-1 -: UW];
            o_frame.data.tangent_z  <= n_pack_out[4*UW-1 -: UW];
            o_frame.data.binormal_x <= n_pack_out[3*UW-1 -: UW];
            o_frame.data.binormal_y <= n_pack_out[2*UW-1 -: UW];
            o_frame.data.binormal_z <= n_pack_out[UW-1 -: UW];
            o_frame.data.normal_x   <= n_u[0];
            o_frame.data.normal_y   <= n_u[1];
            o_frame.data.normal_z   <= n_u[2];
            o_frame.data.degenerate <= n_pack_out[6*UW] | n_z | (|n_side_out);
        end
    end
    assign o_frame.valid = r_out_v;

endmodule

`default_nettype wire
